// ===== src/hfq_pkg.sv =====
// Shared types and constants for the handle queue with remove-by-value.
package hfq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int HANDLE_WIDTH = 64;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int REQ_W   = 3;
    localparam int VALUE_W = 64;
    localparam int OCC_W   = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ   = 3'd0,
        REQ_DEQ   = 3'd1,
        REQ_REM   = 3'd2,
        REQ_START = 3'd3,
        REQ_NEXT  = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [VALUE_W-1:0] item_value;
    } t_in;

    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        t_status            status;
        logic [OCC_W-1:0]   occupancy;
    } t_out;

    typedef struct packed {
        logic    accept;
        logic    end_iter;
        logic    enq;
        logic    pop;
        logic    start_iter;
        logic    read_cursor;
        logic    capture;
        logic    scan_start;
        logic    scan_step;
        logic    shift_wr;
        logic    drop;
        logic    set_status;
        t_status status_code;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             empty;
        logic             full;
        logic             next_ok;
        logic             match;
        logic             last;
        logic             out_busy;
    } t_sts;

endpackage

// ===== src/hfq_ctrl.sv =====
// Controller state machine sequencing each queue request.
module hfq_ctrl import hfq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_READ  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                unique case (t_req'(i_sts.req))
                    REQ_ENQ: begin
                        o_cmd.end_iter = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_FULL;
                        end else begin
                            o_cmd.enq = 1'b1;
                        end
                    end
                    REQ_DEQ: begin
                        o_cmd.end_iter = 1'b1;
                        if (i_sts.empty) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_EMPTY;
                        end else begin
                            o_cmd.pop = 1'b1;
                            n_state   = S_READ;
                        end
                    end
                    REQ_REM: begin
                        o_cmd.end_iter = 1'b1;
                        if (i_sts.empty) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_EMPTY;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    REQ_START: begin
                        o_cmd.start_iter = 1'b1;
                    end
                    REQ_NEXT: begin
                        if (i_sts.next_ok) begin
                            o_cmd.read_cursor = 1'b1;
                            n_state           = S_READ;
                        end else begin
                            o_cmd.end_iter    = 1'b1;
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_EMPTY;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.capture = 1'b1;
                n_state       = S_FIN;
            end
            S_SCAN: begin
                if (i_sts.match) begin
                    if (i_sts.last) begin
                        o_cmd.drop = 1'b1;
                        n_state    = S_FIN;
                    end else begin
                        o_cmd.scan_step = 1'b1;
                        n_state         = S_SHIFT;
                    end
                end else if (i_sts.last) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_NOT_FOUND;
                    n_state           = S_FIN;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_wr = 1'b1;
                if (i_sts.last) begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_FIN;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/hfq_dp.sv =====
// Datapath: entry memory, queue pointers, iteration cursor and result register.
module hfq_dp import hfq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic [HANDLE_WIDTH-1:0] mem [QUEUE_DEPTH];

    logic [IDX_W-1:0]        r_head;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_cursor;
    logic                    r_iter;
    logic [REQ_W-1:0]        r_req;
    logic [HANDLE_WIDTH-1:0] r_item;
    logic [HANDLE_WIDTH-1:0] r_rdata;
    logic [HANDLE_WIDTH-1:0] r_value;
    t_status                 r_status;
    logic [CNT_W-1:0]        r_k;
    logic [IDX_W-1:0]        r_slot;
    logic [IDX_W-1:0]        r_wslot;
    logic                    r_out_valid;
    t_out                    r_out;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [HANDLE_WIDTH-1:0] mem_wdata;
    logic                    mem_re;
    logic [IDX_W-1:0]        mem_raddr;
    logic [IDX_W-1:0]        slot_inc;
    logic [IDX_W-1:0]        head_inc;

    function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return IDX_W'(sum);
    endfunction

    function automatic logic [IDX_W-1:0] inc(input logic [IDX_W-1:0] s);
        return (s == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    assign slot_inc = inc(r_slot);
    assign head_inc = inc(r_head);

    assign mem_we    = i_cmd.enq | i_cmd.shift_wr;
    assign mem_waddr = i_cmd.enq ? wrap(r_head, r_count) : r_wslot;
    assign mem_wdata = i_cmd.enq ? r_item : r_rdata;

    assign mem_re = i_cmd.pop | i_cmd.read_cursor | i_cmd.scan_start | i_cmd.scan_step;

    always_comb begin
        priority if (i_cmd.read_cursor) begin
            mem_raddr = wrap(r_head, r_cursor);
        end else if (i_cmd.scan_step) begin
            mem_raddr = slot_inc;
        end else begin
            mem_raddr = r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_cursor <= '0;
            r_iter   <= 1'b0;
        end else begin
            if (i_cmd.end_iter) begin
                r_iter <= 1'b0;
            end
            if (i_cmd.start_iter) begin
                r_iter   <= 1'b1;
                r_cursor <= '0;
            end
            if (i_cmd.read_cursor) begin
                r_cursor <= r_cursor + 1'b1;
            end
            if (i_cmd.enq) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.pop) begin
                r_head  <= head_inc;
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.drop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req    <= i_in_data.req_type;
            r_item   <= i_in_data.item_value[HANDLE_WIDTH-1:0];
            r_value  <= '0;
            r_status <= ST_OK;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.capture) begin
            r_value <= r_rdata;
        end
        if (i_cmd.scan_start) begin
            r_k    <= '0;
            r_slot <= r_head;
        end
        if (i_cmd.scan_step) begin
            r_k     <= r_k + 1'b1;
            r_slot  <= slot_inc;
            r_wslot <= r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.result_value <= VALUE_W'(r_value);
            r_out.status       <= r_status;
            r_out.occupancy    <= OCC_W'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_sts.req      = r_req;
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_sts.next_ok  = r_iter && (r_cursor < r_count);
    assign o_sts.match    = (r_rdata == r_item);
    assign o_sts.last     = ((r_k + 1'b1) >= r_count);
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

endmodule

// ===== src/handle_fifo_with_removal.sv =====
// Top level of the handle queue with remove-by-value and iteration.
//
//  channel  direction  handshake                  payload
//  request  in         i_in_valid / o_in_ready    i_in_data  (t_in)
//  result   out        o_out_valid / i_out_ready  o_out_data (t_out)
//
// Enqueue, iteration start, unused codes and every empty, full or ended case pass
// from accept through the execute state to the final state; a dequeue or iteration
// next that returns an entry also passes the read state for the registered memory read.
// Removal scans one entry a cycle, then closes up one entry a cycle,
// both through the single memory read port.
// Reset is synchronous and clears the pointers, count, cursor and handshake state.
// A new request is taken while an earlier result waits in the output register;
// a stalled result holds the controller in its final state until taken.
module handle_fifo_with_removal import hfq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cmd cmd;
    t_sts sts;

    hfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hfq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while a transaction is in progress");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !(o_out_valid && !i_out_ready))
        else $error("result register overwritten while stalled");

    a_enq_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.enq |-> !sts.full)
        else $error("enqueue written into a full queue");

endmodule

// ===== verif/tb_handle_fifo_with_removal.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the handle queue with remove-by-value and iteration.
module tb_handle_fifo_with_removal;
    import hfq_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int POOL_SIZE      = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam int WALK_MAX       = QUEUE_DEPTH + 2;

    localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;
    localparam logic [VALUE_W-1:0] HANDLE_MASK =
        (HANDLE_WIDTH >= VALUE_W) ? '1 : ((VALUE_W'(1) << HANDLE_WIDTH) - 1'b1);

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    always #5 i_clk = ~i_clk;

    handle_fifo_with_removal uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    t_in  pending_requests[$];
    t_out expected_results[$];
    logic [VALUE_W-1:0] handle_pool[POOL_SIZE];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int requests_issued = 0;
    int requests_taken  = 0;
    int results_taken   = 0;
    int mismatches      = 0;
    int full_seen       = 0;
    int not_found_seen  = 0;
    int empty_seen      = 0;
    int stall_cycles    = 0;
    int hold_left       = 0;
    bit hold_trigger    = 1'b0;
    bit hold_started    = 1'b0;

    logic [VALUE_W-1:0] queue_store[QUEUE_DEPTH];
    logic [IDX_W-1:0]   queue_head   = '0;
    logic [CNT_W-1:0]   queue_count  = '0;
    logic [OCC_W-1:0]   walk_cursor  = '0;
    logic               walk_active  = 1'b0;

    function automatic int slot_of(int offset);
        return (int'(queue_head) + offset) % QUEUE_DEPTH;
    endfunction

    function automatic t_out predict_queue_result(t_in req);
        t_out               res;
        logic [VALUE_W-1:0] handle;
        int                 hit;
        handle           = req.item_value & HANDLE_MASK;
        res.result_value = '0;
        res.status       = ST_OK;
        if (req.req_type <= REQ_REM) begin
            walk_active = 1'b0;
        end
        case (req.req_type)
            REQ_ENQ: begin
                if (queue_count >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    queue_store[slot_of(queue_count)] = handle;
                    queue_count++;
                end
            end
            REQ_DEQ: begin
                if (queue_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.result_value = queue_store[queue_head];
                    queue_head = IDX_W'(slot_of(1));
                    queue_count--;
                end
            end
            REQ_REM: begin
                if (queue_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    hit = -1;
                    for (int k = 0; k < queue_count; k++) begin
                        if (hit < 0 && queue_store[slot_of(k)] == handle) begin
                            hit = k;
                        end
                    end
                    if (hit < 0) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        for (int k = hit; k + 1 < queue_count; k++) begin
                            queue_store[slot_of(k)] = queue_store[slot_of(k + 1)];
                        end
                        queue_count--;
                    end
                end
            end
            REQ_START: begin
                walk_cursor = '0;
                walk_active = 1'b1;
            end
            REQ_NEXT: begin
                if (!walk_active || walk_cursor >= queue_count) begin
                    res.status  = ST_EMPTY;
                    walk_active = 1'b0;
                end else begin
                    res.result_value = queue_store[slot_of(walk_cursor)];
                    walk_cursor++;
                end
            end
            default: begin
            end
        endcase
        res.result_value = res.result_value & HANDLE_MASK;
        res.occupancy    = OCC_W'(queue_count);
        return res;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_handle();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VALUE_W-1:0] pick_handle(int pool_pct);
        if ($urandom_range(99) < pool_pct) begin
            return handle_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return rand_handle();
    endfunction

    task automatic push_request(logic [REQ_W-1:0] code, logic [VALUE_W-1:0] value);
        t_in req;
        req.req_type   = code;
        req.item_value = value;
        pending_requests.push_back(req);
        requests_issued++;
    endtask

    // enq_pct biases toward filling or draining; iteration comes as a start plus a walk or as a lone next
    task automatic push_request_mix(int decisions, int enq_pct);
        int pick;
        int walk;
        for (int i = 0; i < POOL_SIZE; i++) begin
            handle_pool[i] = rand_handle();
        end
        for (int d = 0; d < decisions; d++) begin
            pick = $urandom_range(99);
            if (pick < enq_pct) begin
                push_request(REQ_ENQ, pick_handle(75));
            end else begin
                pick = $urandom_range(99);
                if (pick < 30) begin
                    push_request(REQ_DEQ, rand_handle());
                end else if (pick < 65) begin
                    push_request(REQ_REM, pick_handle(80));
                end else if (pick < 85) begin
                    push_request(REQ_START, rand_handle());
                    walk = $urandom_range(WALK_MAX, 1);
                    for (int w = 0; w < walk; w++) begin
                        push_request(REQ_NEXT, rand_handle());
                    end
                end else if (pick < 95) begin
                    push_request(REQ_NEXT, rand_handle());
                end else begin
                    push_request(REQ_W'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST)),
                                 rand_handle());
                end
            end
        end
    endtask

    task automatic run_phase(int send_pct, int recv_pct, int chunks, bit with_hold);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (with_hold) begin
            hold_trigger = 1'b1;
        end
        for (int c = 0; c < chunks; c++) begin
            push_request_mix(29, (c % 2 == 0) ? 75 : 25);
        end
        while (requests_taken < requests_issued) begin
            @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_requests.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_cycles = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                want = predict_queue_result(i_in_data);
                expected_results.push_back(want);
                requests_taken++;
                case (want.status)
                    ST_FULL:      full_seen++;
                    ST_NOT_FOUND: not_found_seen++;
                    ST_EMPTY:     empty_seen++;
                    default:      ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                results_taken++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("[%0t] unexpected result value=%h status=%0d occ=%0d",
                                 $realtime, o_out_data.result_value, o_out_data.status,
                                 o_out_data.occupancy);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.result_value !== want.result_value ||
                        o_out_data.status !== want.status ||
                        o_out_data.occupancy !== want.occupancy) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("[%0t] result %0d: expected value=%h status=%0d occ=%0d",
                                     $realtime, results_taken, want.result_value,
                                     want.status, want.occupancy);
                            $display("[%0t] result %0d: actual   value=%h status=%0d occ=%0d",
                                     $realtime, results_taken, o_out_data.result_value,
                                     o_out_data.status, o_out_data.occupancy);
                        end
                    end
                end
            end
            if (hold_trigger && !hold_started) begin
                hold_started = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
                $display("tb_handle_fifo_with_removal: FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue and idle iterator corner cases, then extreme-value enqueues and a walk
        push_request(REQ_DEQ, rand_handle());
        push_request(REQ_REM, rand_handle());
        push_request(REQ_NEXT, rand_handle());
        push_request(REQ_START, rand_handle());
        push_request(REQ_NEXT, rand_handle());
        push_request(REQ_ENQ, '1);
        push_request(REQ_ENQ, '0);
        push_request(REQ_ENQ, 64'h5A5A_A5A5_0F0F_F0F0);
        push_request(REQ_START, '0);
        push_request(REQ_NEXT, '1);
        // queue change ends the walk
        push_request(REQ_ENQ, 64'hA5A5_5A5A_F0F0_0F0F);
        push_request(REQ_NEXT, rand_handle());
        push_request(REQ_REM, 64'h0123_4567_89AB_CDEF);
        push_request(REQ_REM, '0);
        push_request(REQ_START, rand_handle());
        push_request(REQ_NEXT, rand_handle());
        push_request(REQ_NEXT, rand_handle());
        push_request(REQ_NEXT, rand_handle());
        push_request(REQ_NEXT, rand_handle());
        push_request(REQ_NEXT, rand_handle());
        push_request(REQ_SPARE_FIRST, '1);
        push_request(REQ_SPARE_LAST, rand_handle());
        push_request(REQ_DEQ, rand_handle());
        push_request(REQ_REM, 64'hA5A5_5A5A_F0F0_0F0F);

        run_phase(34, 61, 4, 1'b0);
        run_phase(61, 34, 4, 1'b0);
        run_phase(0, 0, 4, 1'b1);

        while (requests_taken < requests_issued || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", expected_results.size());
        end

        $display("Covered %0d requests and %0d results under three idle patterns and a long stall.",
                 requests_taken, results_taken);
        $display("Saw %0d full, %0d not found and %0d empty or end-of-walk results; %0d mismatches.",
                 full_seen, not_found_seen, empty_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb_handle_fifo_with_removal: PASS");
        end else begin
            $display("tb_handle_fifo_with_removal: FAIL");
        end
        $finish;
    end

endmodule
